/* rtl/sha256_pkg.sv */
// Shared types, constants and functions for the SHA-256 hash engine.
// Depends on nothing; the datapath, controller and top level use it.
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PACK,
      ST_PAD,
      ST_LEN,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic       load_word;    // pack the accepted request word
      logic       pad_byte;     // pack the 0x80 byte or a zero
      logic       pad_marker;   // 1: 0x80, 0: zero
      logic       len_word;     // pack one 32-bit half of the bit length
      logic       len_high;     // 1: upper half of the length
      logic       init_vars;    // copy chain value into working variables
      logic       round;        // run one compression round
      logic       fold;         // add working variables into the chain value
      logic       emit_shift;   // rotate chain value toward the output
      logic       reset_msg;    // restore initial hash and clear counters
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       block_full;   // 64 bytes packed
      logic       pad_at_len;   // fill count equals 56
      logic       last_round;   // round 63 is running
   } status_type;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* rtl/sha256_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing.
interface sha256_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        final_word;
   modport source (output valid, message_word, valid_bytes, final_word, input ready);
   modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;
   modport source (output valid, digest_word, digest_last, input ready);
   modport sink (input valid, digest_word, digest_last, output ready);
endinterface

/* rtl/sha256_datapath.sv */
// Datapath: byte packer, rolling schedule, round logic and chain value.
// Depends on sha256_pkg.
module sha256_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::cmd_type    cmd,
   input  logic [31:0]            req_word,
   input  logic [2:0]             req_bytes,
   output sha256_pkg::status_type status,
   output logic [31:0]            digest_head
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] spill_ff, spill_in;

   logic [2:0]  cnt;
   logic [31:0] pack_src;
   logic [2:0]  pack_cnt;
   logic [6:0]  fill_sum;
   logic [31:0] wt, s0, s1, t1, t2;

   always_comb begin
      cnt = (req_bytes > 3'd4) ? 3'd4 : req_bytes;
      pack_src = req_word;
      pack_cnt = 3'd0;
      if (cmd.load_word) begin
         pack_cnt = cnt;
      end else if (cmd.pad_byte) begin
         pack_src = {(cmd.pad_marker ? sha256_pkg::PAD_MARK : 8'h00), 24'h0};
         pack_cnt = 3'd1;
      end else if (cmd.len_word) begin
         pack_src = cmd.len_high ? bits_ff[63:32] : bits_ff[31:0];
         pack_cnt = 3'd4;
      end
      fill_sum = {1'b0, fill_ff} + {4'd0, pack_cnt};
   end

   // Byte packer writes up to four bytes, spanning at most two words.
   always_comb begin
      logic [63:0] pair;
      logic [63:0] mask;
      logic [3:0]  idx0;
      logic [3:0]  idx1;
      logic [31:0] keep0;
      pair = {pack_src, 32'h0} >> {fill_ff[1:0], 3'b000};
      mask = ({32'hffffffff, 32'h0} << {3'd4 - pack_cnt, 3'b000}) >> {fill_ff[1:0], 3'b000};
      idx0 = fill_ff[5:2];
      idx1 = idx0 + 4'd1;
      keep0 = 32'h0;
      spill_in = spill_ff;
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (pack_cnt != 3'd0) begin
         keep0 = (fill_ff[1:0] == 2'd0) ? 32'h0 : w_ff[idx0];
         w_in[idx0] = (keep0 & ~mask[63:32]) | (pair[63:32] & mask[63:32]);
         if (mask[31:0] != 32'h0) begin
            if (fill_sum[6]) begin
               // Bytes past the end of the block wait until it is compressed.
               spill_in = pair[31:0] & mask[31:0];
            end else begin
               w_in[idx1] = pair[31:0] & mask[31:0];
            end
         end
      end
      s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
         ^ (w_ff[14] >> 10);
      wt = w_ff[0];
      if (cmd.round) begin
         // The window shifts each round so entry 0 is always the current word.
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = w_ff[0] + s0 + w_ff[9] + s1;
      end
      if (cmd.fold) begin
         // The next block starts with any bytes held over from the last word.
         w_in[0] = spill_ff;
      end
   end

   always_comb begin
      t1 = v_ff[7]
         + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
            ^ sha256_pkg::rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::ROUND_K[rnd_ff] + wt;
      t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
            ^ sha256_pkg::rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
         h_in[i] = h_ff[i];
      end
      rnd_in = rnd_ff;
      if (cmd.init_vars) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = h_ff[i];
         end
         rnd_in = 6'd0;
      end else if (cmd.round) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
         rnd_in = rnd_ff + 6'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end else if (cmd.emit_shift) begin
         for (int i = 0; i < 7; i++) begin
            h_in[i] = h_ff[i + 1];
         end
         h_in[7] = h_ff[0];
      end else if (cmd.reset_msg) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = sha256_pkg::IV[i];
         end
      end
      fill_in = fill_sum[5:0];
      bits_in = bits_ff;
      if (cmd.load_word) begin
         bits_in = bits_ff + {58'd0, cnt, 3'b000};
      end
      if (cmd.reset_msg) begin
         fill_in = 6'd0;
         bits_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      spill_ff <= spill_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha256_pkg::IV[i];
            v_ff[i] <= 32'h0;
         end
         fill_ff <= 6'd0;
         bits_ff <= 64'd0;
         rnd_ff  <= 6'd0;
      end else begin
         h_ff    <= h_in;
         v_ff    <= v_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         rnd_ff  <= rnd_in;
      end
   end

   assign status.block_full = fill_sum[6];
   assign status.pad_at_len = (fill_ff == sha256_pkg::LEN_POS);
   assign status.last_round = (rnd_ff == 6'd63);
   assign digest_head = h_ff[0];

endmodule

/* rtl/sha256_control.sv */
// Controller state machine sequencing packing, padding, rounds and output.
// Depends on sha256_pkg.
module sha256_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_final,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_last,
   input  sha256_pkg::status_type status,
   output sha256_pkg::cmd_type    cmd
);

   sha256_pkg::state_type state_ff, state_in;
   sha256_pkg::state_type ret_ff, ret_in;
   logic       final_ff, final_in;
   logic       lenhi_ff, lenhi_in;
   logic [2:0] emit_ff, emit_in;

   // Next-state logic. After a compression, ret_ff says where to resume.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      final_in = final_ff;
      lenhi_in = lenhi_ff;
      emit_in  = emit_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE, sha256_pkg::ST_PACK: begin
            if (req_valid) begin
               final_in = req_final;
               lenhi_in = 1'b1;
               if (status.block_full) begin
                  state_in = sha256_pkg::ST_INIT;
                  ret_in = req_final ? sha256_pkg::ST_PAD : sha256_pkg::ST_PACK;
               end else if (req_final) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            // The marker byte goes first; then zeros until 56 bytes are held.
            if (final_ff) begin
               final_in = 1'b0;
               if (status.block_full) begin
                  state_in = sha256_pkg::ST_INIT;
                  ret_in = sha256_pkg::ST_PAD;
               end
            end else if (status.pad_at_len) begin
               state_in = sha256_pkg::ST_LEN;
            end else if (status.block_full) begin
               state_in = sha256_pkg::ST_INIT;
               ret_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_LEN: begin
            lenhi_in = 1'b0;
            if (!lenhi_ff) begin
               state_in = sha256_pkg::ST_INIT;
               ret_in = sha256_pkg::ST_EMIT;
            end
         end
         sha256_pkg::ST_INIT: begin
            state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            if (status.last_round) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            state_in = ret_ff;
            emit_in = 3'd0;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  state_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   // Output logic.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE, sha256_pkg::ST_PACK: begin
            req_ready = 1'b1;
            cmd.load_word = req_valid;
         end
         sha256_pkg::ST_PAD: begin
            cmd.pad_byte = final_ff || !status.pad_at_len;
            cmd.pad_marker = final_ff;
         end
         sha256_pkg::ST_LEN: begin
            cmd.len_word = 1'b1;
            cmd.len_high = lenhi_ff;
         end
         sha256_pkg::ST_INIT: begin
            cmd.init_vars = 1'b1;
         end
         sha256_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         sha256_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         sha256_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last = (emit_ff == 3'd7);
            cmd.emit_shift = rsp_ready && (emit_ff != 3'd7);
            cmd.reset_msg = rsp_ready && (emit_ff == 3'd7);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         ret_ff   <= sha256_pkg::ST_PACK;
         final_ff <= 1'b0;
         lenhi_ff <= 1'b1;
         emit_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         final_ff <= final_in;
         lenhi_ff <= lenhi_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

/* rtl/sha256_hash_engine.sv */
// Top level of the SHA-256 hash engine: controller plus datapath.
// Depends on sha256_pkg, sha256_if, sha256_control and sha256_datapath.
//
// The engine hashes a byte message that arrives as request words of up to four
// big-endian bytes each, the final request marked by final_word (valid_bytes
// may be zero there, which also covers the empty message). A request word is
// packed as it is accepted; a word that runs past the end of a block keeps its
// spare bytes for the next block. Each full 64-byte block then runs the
// compression at one round per cycle through a shifting 16-word schedule
// window (load, 64 rounds, fold); requests are held off during the compression.
// After the final request the controller packs the 0x80 byte and zero fill one
// byte per cycle while no compression runs (up to 64 bytes, until the fill
// reaches 56 bytes), then the 64-bit bit length as two 32-bit halves, upper
// first, runs one or two more compressions and offers the eight digest words,
// H0 first, on the response channel, the eighth with digest_last set. The
// response word comes straight from the chain-value register, so a stalled
// response holds steady. Once the eighth word is taken the engine returns to
// the initial hash values.
module sha256_hash_engine (
   input  logic              clock,
   input  logic              reset,
   sha256_req_if.sink        req,
   sha256_rsp_if.source      rsp
);

   sha256_pkg::cmd_type    cmd;
   sha256_pkg::status_type status;

   sha256_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_final (req.final_word),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_last  (rsp.digest_last),
      .status    (status),
      .cmd       (cmd)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req.message_word),
      .req_bytes   (req.valid_bytes),
      .status      (status),
      .digest_head (rsp.digest_word)
   );

endmodule
